// ===== hw/rtl/fpwa_pkg.sv =====
// Shared types and constants for the page write allocator.
// No dependencies; the interfaces, the top level and the testbench refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package fpwa_pkg;
	localparam int NUM_BLOCKS      = 256;
	localparam int BLOCK_PAGES     = 64;
	localparam int NUM_LPNS        = 8192;
	localparam int MAX_STREAMS     = 8;

	localparam int LPN_W   = 13;
	localparam int BLK_W   = 8;
	localparam int OFS_W   = 6;
	localparam int PPN_W   = BLK_W + OFS_W;
	localparam int STR_W   = 3;
	localparam int CFG_W   = 4;
	localparam int INV_W   = 7;
	localparam int FCNT_W  = 9;
	localparam int WCNT_W  = 32;
	localparam int MAP_W   = PPN_W + 1;
	localparam int META_W  = LPN_W + STR_W;
	localparam int CLR_W   = 14;

	localparam logic [INV_W-1:0]  INV_MAX     = 7'd127;
	localparam logic [CFG_W-1:0]  SC_MIN      = 4'd2;
	localparam logic [CFG_W-1:0]  SC_MAX      = 4'd8;
	localparam logic [CFG_W-1:0]  SC_RESET    = 4'd4;
	localparam logic [FCNT_W-1:0] FIFO_FULL   = 9'd256;
	localparam logic [CLR_W-1:0]  CLR_LAST    = 14'd8191;
	localparam logic [CLR_W-1:0]  CLR_BLOCKS  = 14'd256;
	localparam logic [OFS_W-1:0]  OFS_LAST    = 6'd63;

	typedef enum logic [1:0] {
		REQ_HOST = 2'd0,
		REQ_GC   = 2'd1,
		REQ_FREE = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFREE  = 2'd1,
		ST_UNMAPPED = 2'd2
	} status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/fpwa_req_if.sv =====
// Request channel: valid/ready handshake with the write request payload.
// Depends on fpwa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface fpwa_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   req_type;
	logic [fpwa_pkg::LPN_W-1:0]   lpn;
	logic [fpwa_pkg::BLK_W-1:0]   freed_block;
	modport source (output valid, req_type, lpn, freed_block, input ready);
	modport sink (input valid, req_type, lpn, freed_block, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fpwa_rsp_if.sv =====
// Response channel: valid/ready handshake with the allocation result.
// Depends on fpwa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface fpwa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [fpwa_pkg::PPN_W-1:0]    ppn;
	logic [fpwa_pkg::STR_W-1:0]    stream;
	logic                          old_valid;
	logic [fpwa_pkg::BLK_W-1:0]    old_block;
	logic [fpwa_pkg::WCNT_W-1:0]   write_count;
	modport source (output valid, status, ppn, stream, old_valid, old_block, write_count,
		input ready);
	modport sink (input valid, status, ppn, stream, old_valid, old_block, write_count,
		output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fpwa_cfg_if.sv =====
// Configuration write channel carrying the stream count register.
// Depends on fpwa_pkg for the register width.
`timescale 1ns / 1ps
`default_nettype none
interface fpwa_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [fpwa_pkg::CFG_W-1:0]  data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fpwa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fpwa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ftl_page_write_allocator.sv =====
// Top level of the page write allocator: sequencer, stream registers, memories.
// Depends on fpwa_pkg, the fpwa_*_if interfaces and fpwa_ram.
`timescale 1ns / 1ps
`default_nettype none
// Each request takes three steps from acceptance to a registered result: one
// step reads the map table and the free FIFO head, one reads the page metadata
// (GC) or the block's invalid count (host), and one, when the output register is
// free, writes map, metadata, invalid count and FIFO back and updates the stream
// registers. A new request is taken once the previous one has written back, while
// its result may still wait in the output register. After reset an initialization
// pass clears the map, zeroes the invalid counts and fills the free FIFO with
// blocks in order; no request is taken during it, configuration writes are.
module ftl_page_write_allocator (
	input wire logic   clk,
	input wire logic   arst_n,
	fpwa_req_if.sink   req,
	fpwa_rsp_if.source rsp,
	fpwa_cfg_if.sink   cfg
);
	typedef enum logic [1:0] {S_IDLE, S_RD1, S_RD2} state_t;

	state_t state_q;
	logic                              clr_q;
	logic [fpwa_pkg::CLR_W-1:0]        clr_idx_q;
	logic [fpwa_pkg::CFG_W-1:0]        sc_q;
	logic [1:0]                        type_s1;
	logic [fpwa_pkg::LPN_W-1:0]        lpn_s1;
	logic [fpwa_pkg::BLK_W-1:0]        fb_s1;
	logic [fpwa_pkg::BLK_W-1:0]        head_q;
	logic [fpwa_pkg::FCNT_W-1:0]       fcnt_q;
	logic [fpwa_pkg::BLK_W-1:0]        oblk_q [fpwa_pkg::MAX_STREAMS];
	logic                              oval_q [fpwa_pkg::MAX_STREAMS];
	logic [fpwa_pkg::OFS_W-1:0]        ofs_q  [fpwa_pkg::MAX_STREAMS];
	logic [fpwa_pkg::WCNT_W-1:0]       wcnt_q;

	logic                              rsp_valid_q;
	logic [1:0]                        status_q;
	logic [fpwa_pkg::PPN_W-1:0]        ppn_q;
	logic [fpwa_pkg::STR_W-1:0]        stream_q;
	logic                              old_valid_q;
	logic [fpwa_pkg::BLK_W-1:0]        old_block_q;

	logic [fpwa_pkg::MAP_W-1:0]        map_rdata;
	logic [fpwa_pkg::META_W-1:0]       meta_rdata;
	logic [fpwa_pkg::INV_W-1:0]        inv_rdata;
	logic [fpwa_pkg::BLK_W-1:0]        fifo_rdata;

	logic accept, exec;
	logic ex_map_we, ex_meta_we, ex_inv_we, ex_fifo_we;
	logic [fpwa_pkg::BLK_W-1:0]   ex_inv_addr, ex_fifo_addr;
	logic [fpwa_pkg::INV_W-1:0]   ex_inv_data;
	logic [fpwa_pkg::PPN_W-1:0]   new_ppn;
	logic [fpwa_pkg::STR_W-1:0]   sel, out_stream;
	logic                         upd, new_oval, pop, push, placed, out_old_v;
	logic [fpwa_pkg::BLK_W-1:0]   new_oblk, ob, out_old_b;
	logic [fpwa_pkg::OFS_W-1:0]   new_ofs, off;
	logic [1:0]                   out_status;
	logic [fpwa_pkg::CFG_W-1:0]   sc, sc_m1, s4;
	logic                         map_hit;
	logic [fpwa_pkg::BLK_W-1:0]   old_blk;
	logic                         clr_blk;

	logic                         map_we, inv_we, fifo_we;
	logic [fpwa_pkg::LPN_W-1:0]   map_waddr;
	logic [fpwa_pkg::MAP_W-1:0]   map_wdata;
	logic [fpwa_pkg::BLK_W-1:0]   inv_waddr, fifo_waddr, fifo_wdata;
	logic [fpwa_pkg::INV_W-1:0]   inv_wdata;

	assign req.ready = (state_q == S_IDLE) && !clr_q;
	assign cfg.ready = 1'b1;
	assign accept    = req.valid && req.ready;
	assign exec      = (state_q == S_RD2) && (!rsp_valid_q || rsp.ready);

	assign map_hit = map_rdata[fpwa_pkg::MAP_W-1];
	assign old_blk = map_rdata[fpwa_pkg::PPN_W-1:fpwa_pkg::OFS_W];
	assign clr_blk = clr_idx_q < fpwa_pkg::CLR_BLOCKS;

	always_comb begin
		sc = sc_q;
		if (sc_q < fpwa_pkg::SC_MIN) begin
			sc = fpwa_pkg::SC_MIN;
		end else if (sc_q > fpwa_pkg::SC_MAX) begin
			sc = fpwa_pkg::SC_MAX;
		end
		sc_m1 = sc - 4'd1;
		if ({1'b0, meta_rdata[fpwa_pkg::STR_W-1:0]} < sc_m1) begin
			s4 = {1'b0, meta_rdata[fpwa_pkg::STR_W-1:0]} + 4'd1;
		end else begin
			s4 = sc_m1;
		end
	end

	always_comb begin
		ex_map_we    = 1'b0;
		ex_meta_we   = 1'b0;
		ex_inv_we    = 1'b0;
		ex_fifo_we   = 1'b0;
		ex_inv_addr  = old_blk;
		ex_inv_data  = (inv_rdata < fpwa_pkg::INV_MAX) ? inv_rdata + 7'd1 : inv_rdata;
		ex_fifo_addr = head_q + fcnt_q[fpwa_pkg::BLK_W-1:0];
		sel          = '0;
		upd          = 1'b0;
		new_oval     = 1'b1;
		new_oblk     = '0;
		new_ofs      = '0;
		pop          = 1'b0;
		push         = 1'b0;
		placed       = 1'b0;
		ob           = '0;
		off          = '0;
		out_status   = fpwa_pkg::ST_OK;
		out_stream   = '0;
		out_old_v    = 1'b0;
		out_old_b    = '0;
		case (type_s1)
			fpwa_pkg::REQ_HOST: begin
				if (ofs_q[0] == '0 && fcnt_q == '0) begin
					out_status = fpwa_pkg::ST_NOFREE;
				end else begin
					ob       = (ofs_q[0] == '0) ? fifo_rdata : oblk_q[0];
					off      = ofs_q[0];
					placed   = 1'b1;
					upd      = 1'b1;
					new_oblk = ob;
					new_ofs  = off + 6'd1;
					if (map_hit) begin
						out_old_v = 1'b1;
						out_old_b = old_blk;
						ex_inv_we = 1'b1;
					end
					if (off == fpwa_pkg::OFS_LAST && fcnt_q != '0) begin
						pop = 1'b1;
					end
				end
			end
			fpwa_pkg::REQ_GC: begin
				sel = s4[fpwa_pkg::STR_W-1:0];
				if (!map_hit) begin
					out_status = fpwa_pkg::ST_UNMAPPED;
					sel        = '0;
				end else if (!oval_q[sel] && fcnt_q == '0) begin
					out_status = fpwa_pkg::ST_NOFREE;
					out_stream = sel;
				end else begin
					out_stream = sel;
					placed     = 1'b1;
					upd        = 1'b1;
					if (oval_q[sel]) begin
						ob  = oblk_q[sel];
						off = ofs_q[sel];
					end else begin
						ob  = fifo_rdata;
						off = '0;
						pop = 1'b1;
					end
					new_oblk = ob;
					new_ofs  = off + 6'd1;
					if (off == fpwa_pkg::OFS_LAST) begin
						if (fcnt_q != '0) begin
							pop      = 1'b1;
							new_oblk = fifo_rdata;
						end else begin
							new_oval = 1'b0;
						end
					end
				end
			end
			fpwa_pkg::REQ_FREE: begin
				if (fcnt_q < fpwa_pkg::FIFO_FULL) begin
					push        = 1'b1;
					ex_fifo_we  = 1'b1;
					ex_inv_we   = 1'b1;
					ex_inv_addr = fb_s1;
					ex_inv_data = '0;
				end
			end
			default: begin
				out_status = fpwa_pkg::ST_OK;
			end
		endcase
		new_ppn    = {ob, off};
		ex_map_we  = placed;
		ex_meta_we = placed;
	end

	always_comb begin
		map_we     = clr_q || (exec && ex_map_we);
		map_waddr  = clr_q ? clr_idx_q[fpwa_pkg::LPN_W-1:0] : lpn_s1;
		map_wdata  = clr_q ? '0 : {1'b1, new_ppn};
		inv_we     = (clr_q && clr_blk) || (exec && ex_inv_we);
		inv_waddr  = clr_q ? clr_idx_q[fpwa_pkg::BLK_W-1:0] : ex_inv_addr;
		inv_wdata  = clr_q ? '0 : ex_inv_data;
		fifo_we    = (clr_q && clr_blk) || (exec && ex_fifo_we);
		fifo_waddr = clr_q ? clr_idx_q[fpwa_pkg::BLK_W-1:0] : ex_fifo_addr;
		fifo_wdata = clr_q ? clr_idx_q[fpwa_pkg::BLK_W-1:0] : fb_s1;
	end

	fpwa_ram #(.WIDTH(fpwa_pkg::MAP_W), .DEPTH(fpwa_pkg::NUM_LPNS)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.re(accept), .raddr(req.lpn), .rdata(map_rdata)
	);

	fpwa_ram #(.WIDTH(fpwa_pkg::META_W),
		.DEPTH(fpwa_pkg::NUM_BLOCKS * fpwa_pkg::BLOCK_PAGES)) u_meta (
		.clk(clk), .we(exec && ex_meta_we), .waddr(new_ppn),
		.wdata({lpn_s1, out_stream}),
		.re(state_q == S_RD1), .raddr(map_rdata[fpwa_pkg::PPN_W-1:0]), .rdata(meta_rdata)
	);

	fpwa_ram #(.WIDTH(fpwa_pkg::INV_W), .DEPTH(fpwa_pkg::NUM_BLOCKS)) u_inv (
		.clk(clk), .we(inv_we), .waddr(inv_waddr), .wdata(inv_wdata),
		.re(state_q == S_RD1), .raddr(old_blk), .rdata(inv_rdata)
	);

	fpwa_ram #(.WIDTH(fpwa_pkg::BLK_W), .DEPTH(fpwa_pkg::NUM_BLOCKS)) u_fifo (
		.clk(clk), .we(fifo_we), .waddr(fifo_waddr), .wdata(fifo_wdata),
		.re(accept), .raddr(head_q), .rdata(fifo_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clr_q       <= 1'b1;
			clr_idx_q   <= '0;
			sc_q        <= fpwa_pkg::SC_RESET;
			head_q      <= '0;
			fcnt_q      <= fpwa_pkg::FIFO_FULL;
			wcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < fpwa_pkg::MAX_STREAMS; i++) begin
				oval_q[i] <= 1'b0;
				ofs_q[i]  <= '0;
			end
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 14'd1;
				if (clr_idx_q == fpwa_pkg::CLR_LAST) begin
					clr_q <= 1'b0;
				end
			end
			if (cfg.valid) begin
				sc_q <= cfg.data;
			end
			if (exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					state_q <= S_RD2;
				end
				S_RD2: begin
					if (exec) begin
						state_q <= S_IDLE;
						if (upd) begin
							oval_q[sel] <= new_oval;
							ofs_q[sel]  <= new_ofs;
						end
						if (placed) begin
							wcnt_q <= wcnt_q + 32'd1;
						end
						if (pop) begin
							head_q <= head_q + 8'd1;
							fcnt_q <= fcnt_q - 9'd1;
						end else if (push) begin
							fcnt_q <= fcnt_q + 9'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1 <= req.req_type;
			lpn_s1  <= req.lpn;
			fb_s1   <= req.freed_block;
		end
		if (exec) begin
			if (upd) begin
				oblk_q[sel] <= new_oblk;
			end
			status_q    <= out_status;
			ppn_q       <= placed ? new_ppn : '0;
			stream_q    <= out_stream;
			old_valid_q <= out_old_v;
			old_block_q <= out_old_b;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.ppn         = ppn_q;
	assign rsp.stream      = stream_q;
	assign rsp.old_valid   = old_valid_q;
	assign rsp.old_block   = old_block_q;
	assign rsp.write_count = wcnt_q;
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for ftl_page_write_allocator: directed table, then random requests.
// Depends on fpwa_pkg, the fpwa_*_if interfaces and the RTL; predicts every response itself.
`timescale 1ns / 1ps
module tb;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [12:0] lpn;
		logic [7:0]  freed_block;
	} wreq_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [13:0] ppn;
		logic [2:0]  stream;
		logic        old_valid;
		logic [7:0]  old_block;
		logic [31:0] write_count;
	} alloc_t;

	typedef struct {
		wreq_t  r;
		logic   known;
		alloc_t res;
		int     cfg;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #10 clk = ~clk;

	fpwa_req_if req();
	fpwa_rsp_if rsp();
	fpwa_cfg_if cfg();

	ftl_page_write_allocator dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	// predictor state
	logic [3:0]  m_sc;
	logic [13:0] m_map [fpwa_pkg::NUM_LPNS];
	logic        m_mapv [fpwa_pkg::NUM_LPNS];
	logic [2:0]  m_cnt [fpwa_pkg::NUM_BLOCKS*fpwa_pkg::BLOCK_PAGES];
	logic [6:0]  m_inv [fpwa_pkg::NUM_BLOCKS];
	logic [7:0]  m_fifo [fpwa_pkg::NUM_BLOCKS];
	logic [7:0]  m_head;
	int          m_fcount;
	logic [7:0]  m_open [fpwa_pkg::MAX_STREAMS];
	logic        m_openv [fpwa_pkg::MAX_STREAMS];
	int          m_ofs [fpwa_pkg::MAX_STREAMS];
	logic [31:0] m_written;

	alloc_t expected_q [$];
	int errors = 0;
	int cycles = 0;
	int rsp_wait = 0;
	bit rsp_gate = 1'b1;

	task automatic model_reset();
		m_sc = fpwa_pkg::SC_RESET;
		for (int i = 0; i < fpwa_pkg::NUM_LPNS; i++) m_mapv[i] = 1'b0;
		for (int i = 0; i < fpwa_pkg::NUM_BLOCKS; i++) begin
			m_inv[i] = '0;
			m_fifo[i] = i[7:0];
		end
		m_head = '0;
		m_fcount = fpwa_pkg::NUM_BLOCKS;
		for (int i = 0; i < fpwa_pkg::MAX_STREAMS; i++) begin
			m_openv[i] = 1'b0;
			m_open[i] = '0;
			m_ofs[i] = 0;
		end
		m_written = '0;
	endtask

	function automatic logic [7:0] pop_free();
		logic [7:0] b;
		b = m_fifo[m_head];
		m_head = m_head + 8'd1;
		m_fcount--;
		return b;
	endfunction

	function automatic logic [13:0] place(int s, logic [12:0] lpn);
		logic [13:0] p;
		p = {m_open[s], m_ofs[s][5:0]};
		m_cnt[p] = s[2:0];
		m_map[lpn] = p;
		m_mapv[lpn] = 1'b1;
		m_ofs[s]++;
		m_written++;
		return p;
	endfunction

	function automatic alloc_t allocate(wreq_t r);
		alloc_t o;
		int sc, s, c;
		o = '0;
		sc = m_sc < fpwa_pkg::SC_MIN ? fpwa_pkg::SC_MIN :
			(m_sc > fpwa_pkg::SC_MAX ? fpwa_pkg::SC_MAX : m_sc);
		if (r.req_type == fpwa_pkg::REQ_HOST) begin
			if (m_ofs[0] == 0 && m_fcount == 0) o.status = fpwa_pkg::ST_NOFREE;
			else begin
				if (m_ofs[0] == 0) begin
					m_open[0] = m_fifo[m_head];
					m_openv[0] = 1'b1;
				end
				if (m_mapv[r.lpn]) begin
					o.old_block = m_map[r.lpn][13:6];
					o.old_valid = 1'b1;
					if (m_inv[o.old_block] < fpwa_pkg::INV_MAX) m_inv[o.old_block]++;
				end
				o.ppn = place(0, r.lpn);
				if (m_ofs[0] >= fpwa_pkg::BLOCK_PAGES) begin
					if (m_fcount != 0) void'(pop_free());
					m_ofs[0] = 0;
				end
			end
		end else if (r.req_type == fpwa_pkg::REQ_GC) begin
			if (!m_mapv[r.lpn]) o.status = fpwa_pkg::ST_UNMAPPED;
			else begin
				c = m_cnt[m_map[r.lpn]];
				s = c < sc - 1 ? c + 1 : sc - 1;
				o.stream = s[2:0];
				if (!m_openv[s] && m_fcount == 0) o.status = fpwa_pkg::ST_NOFREE;
				else begin
					if (!m_openv[s]) begin
						m_open[s] = pop_free();
						m_openv[s] = 1'b1;
						m_ofs[s] = 0;
					end
					o.ppn = place(s, r.lpn);
					if (m_ofs[s] >= fpwa_pkg::BLOCK_PAGES) begin
						m_ofs[s] = 0;
						if (m_fcount != 0) m_open[s] = pop_free();
						else m_openv[s] = 1'b0;
					end
				end
			end
		end else if (r.req_type == fpwa_pkg::REQ_FREE) begin
			if (m_fcount < fpwa_pkg::NUM_BLOCKS) begin
				m_fifo[(m_head + m_fcount) % fpwa_pkg::NUM_BLOCKS] = r.freed_block;
				m_fcount++;
				m_inv[r.freed_block] = '0;
			end
		end
		o.write_count = m_written;
		return o;
	endfunction

	task automatic pause(int n);
		repeat (n) @(negedge clk);
	endtask

	task automatic write_stream_count(logic [3:0] v);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		m_sc = v;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		pause(10);
	endtask

	task automatic send(wreq_t r, logic known, alloc_t res);
		alloc_t e;
		int n;
		n = $urandom_range(0, 10);
		if (n != 0) begin
			req.valid <= 1'b0;
			pause(n);
		end
		req.valid <= 1'b1;
		req.req_type <= r.req_type;
		req.lpn <= r.lpn;
		req.freed_block <= r.freed_block;
		do @(posedge clk); while (!req.ready);
		e = allocate(r);
		if (known && e !== res) begin
			errors++;
			if (errors <= 10)
				$display("table mismatch: expected %h got %h", res, e);
		end
		expected_q.push_back(e);
		@(negedge clk);
	endtask

	// response side
	always @(negedge clk) begin
		if (rsp_gate && rsp_wait > 0) begin
			rsp.ready <= 1'b0;
			rsp_wait--;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		alloc_t got, want;
		cycles++;
		if (arst_n && rsp.valid && rsp.ready) begin
			rsp_wait = $urandom_range(0, 10);
			got = '{rsp.status, rsp.ppn, rsp.stream, rsp.old_valid, rsp.old_block,
				rsp.write_count};
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected response %h", got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: expected st=%0d ppn=%0d str=%0d ov=%0d ",
							"ob=%0d wc=%0d got st=%0d ppn=%0d str=%0d ov=%0d ob=%0d wc=%0d"},
							want.status, want.ppn, want.stream, want.old_valid,
							want.old_block, want.write_count, got.status, got.ppn,
							got.stream, got.old_valid, got.old_block, got.write_count);
				end
			end
		end
		if (cycles > 2000000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic row_t mk(logic [1:0] t, logic [12:0] l, logic [7:0] f, logic k,
		alloc_t res, int c);
		row_t x;
		x.r = '{t, l, f};
		x.known = k;
		x.res = res;
		x.cfg = c;
		return x;
	endfunction

	row_t table_q [$];

	function automatic wreq_t rand_req(int lmax);
		wreq_t r;
		int p;
		p = $urandom_range(0, 99);
		r.req_type = p < 55 ? fpwa_pkg::REQ_HOST : (p < 88 ? fpwa_pkg::REQ_GC :
			(p < 98 ? fpwa_pkg::REQ_FREE : REQ_UNUSED));
		r.lpn = 13'($urandom_range(0, lmax));
		r.freed_block = 8'($urandom_range(0, 255));
		return r;
	endfunction

	initial begin
		wreq_t r;
		int lmax;
		logic [7:0] fb;
		req.valid = 1'b0;
		req.req_type = '0;
		req.lpn = '0;
		req.freed_block = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		model_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		table_q.push_back(mk(fpwa_pkg::REQ_GC, 13'd0, 8'd0, 1'b1,
			'{fpwa_pkg::ST_UNMAPPED, 0, 0, 0, 0, 0}, -1));
		table_q.push_back(mk(fpwa_pkg::REQ_HOST, 13'd0, 8'd0, 1'b1,
			'{fpwa_pkg::ST_OK, 0, 0, 0, 0, 1}, -1));
		table_q.push_back(mk(fpwa_pkg::REQ_HOST, 13'd8191, 8'd0, 1'b1,
			'{fpwa_pkg::ST_OK, 1, 0, 0, 0, 2}, -1));
		table_q.push_back(mk(fpwa_pkg::REQ_HOST, 13'd0, 8'd0, 1'b1,
			'{fpwa_pkg::ST_OK, 2, 0, 1, 0, 3}, -1));
		table_q.push_back(mk(fpwa_pkg::REQ_GC, 13'd0, 8'd0, 1'b1,
			'{fpwa_pkg::ST_OK, 0, 1, 0, 0, 4}, -1));
		table_q.push_back(mk(fpwa_pkg::REQ_GC, 13'd0, 8'd0, 1'b0, '0, -1));
		table_q.push_back(mk(fpwa_pkg::REQ_GC, 13'd0, 8'd0, 1'b0, '0, -1));
		table_q.push_back(mk(fpwa_pkg::REQ_GC, 13'd0, 8'd0, 1'b0, '0, 15));
		table_q.push_back(mk(fpwa_pkg::REQ_GC, 13'd0, 8'd0, 1'b0, '0, -1));
		table_q.push_back(mk(fpwa_pkg::REQ_GC, 13'd8191, 8'd0, 1'b0, '0, 0));
		table_q.push_back(mk(fpwa_pkg::REQ_GC, 13'd0, 8'd0, 1'b0, '0, -1));
		table_q.push_back(mk(fpwa_pkg::REQ_FREE, 13'd8191, 8'd255, 1'b1,
			'{fpwa_pkg::ST_OK, 0, 0, 0, 0, 10}, -1));
		table_q.push_back(mk(REQ_UNUSED, 13'd8191, 8'd255, 1'b1,
			'{fpwa_pkg::ST_OK, 0, 0, 0, 0, 10}, 8));
		table_q.push_back(mk(fpwa_pkg::REQ_HOST, 13'd5461, 8'd170, 1'b0, '0, -1));
		table_q.push_back(mk(fpwa_pkg::REQ_GC, 13'd5461, 8'd85, 1'b0, '0, -1));

		foreach (table_q[i]) begin
			if (table_q[i].cfg >= 0) begin
				drain();
				write_stream_count(table_q[i].cfg[3:0]);
			end
			send(table_q[i].r, table_q[i].known, table_q[i].res);
		end

		// random phases with varied settings and lpn spread
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_stream_count(ph == 0 ? 4'd2 : ph == 1 ? 4'd8 : 4'($urandom_range(0, 15)));
			lmax = ph % 2 ? 8191 : 63;
			for (int n = 0; n < 100; n++) begin
				if (ph == 2 && n == 50) drain();
				r = rand_req(lmax);
				send(r, 1'b0, '0);
			end
		end

		// hold the response side ready, then return blocks
		drain();
		write_stream_count(4'd3);
		rsp_gate = 1'b0;
		for (int n = 0; n < 40; n++) begin
			r = rand_req(8191);
			if (r.req_type == fpwa_pkg::REQ_FREE) r.req_type = fpwa_pkg::REQ_GC;
			send(r, 1'b0, '0);
		end
		for (int n = 0; n < 20; n++) begin
			fb = 8'($urandom_range(0, 255));
			send('{fpwa_pkg::REQ_FREE, 13'd0, fb}, 1'b0, '0);
		end
		rsp_gate = 1'b1;
		for (int n = 0; n < 40; n++) send(rand_req(8191), 1'b0, '0);

		drain();
		pause(20);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ===== ftl_page_write_allocator.f =====
hw/rtl/fpwa_pkg.sv
hw/rtl/fpwa_req_if.sv
hw/rtl/fpwa_rsp_if.sv
hw/rtl/fpwa_cfg_if.sv
hw/rtl/fpwa_ram.sv
hw/rtl/ftl_page_write_allocator.sv
test/tb.sv
